FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the weighted correlation accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCA_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("weighted correlation check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WCA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("weighted correlation check failed");

`endif

FILE: rtl/core/wca_pkg.sv
// Shared types and constants of the weighted correlation accumulator.
`timescale 1ns / 1ps
`default_nettype none

package wca_pkg;

    localparam int MUL_W      = 32;     // shared multiplier operand width
    localparam int LIMB_W     = 32;     // limb width of the squaring steps
    localparam int BIG_W      = 128;    // product of two 64-bit magnitudes
    localparam int SUM_W      = 66;     // headroom for the saturating add
    localparam int Q_W        = 15;     // quotient bits found by the root search
    localparam int ROOT_STEPS = 15;
    localparam int ROOT_SHIFT = 28;     // two Q1.14 fractions
    localparam int ONE_Q14    = 16384;
    localparam int COEF_W     = 16;
    localparam int CNT_W      = 4;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_MAG,
        DP_WLO,
        DP_WHI,
        DP_ACC,
        DP_SQ_MUL,
        DP_LOAD_R,
        DP_LOAD_B,
        DP_ROOT_A,
        DP_ROOT_B,
        DP_EMIT
    } dp_op_t;

    typedef enum logic [1:0] {
        TERM_CROSS,
        TERM_XX,
        TERM_YY
    } term_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG,
        ST_WLO,
        ST_WHI,
        ST_ACC,
        ST_CHECK,
        ST_SQC,
        ST_LDR,
        ST_SQB,
        ST_LDB,
        ST_RTA,
        ST_RTB,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        term_t  term;
        logic   limb_a;
        logic   limb_b;
        logic   first;
        logic   sq_pair;    // 0: cross times cross, 1: xx times yy
    } wca_cmd_t;

    typedef struct packed {
        logic last;
        logic degen;
        logic out_free;
    } wca_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/wca_datapath.sv
// Datapath: shared multiplier, saturating sums, root search and result register.
`timescale 1ns / 1ps
`default_nettype none

module wca_datapath
    import wca_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int WEIGHT_WIDTH = 16,
    parameter int ACC_WIDTH    = 64
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_enable,
    input  wire logic                           cfg_write_data,
    input  wire logic signed [SAMPLE_WIDTH-1:0] x_value,
    input  wire logic signed [SAMPLE_WIDTH-1:0] y_value,
    input  wire logic        [WEIGHT_WIDTH-1:0] weight,
    input  wire logic                           last,
    input  wire wca_cmd_t                       cmd,
    output      wca_status_t                    status,
    input  wire logic                           out_stall,
    output      logic                           out_valid,
    output      logic signed [COEF_W-1:0]       coefficient,
    output      logic                           degenerate,
    output      logic                           saturated
);

    localparam int SW         = SAMPLE_WIDTH;
    localparam int WW         = WEIGHT_WIDTH;
    localparam int AW         = ACC_WIDTH;
    localparam int MW         = 2 * SW;
    localparam int PW         = 2 * SW + WW;
    localparam int PROD_SHIFT = (PW > 64) ? (PW - 64) : 0;
    localparam int RW         = 2 * AW + 30;

    logic          use_weights_reg;
    logic [SW-1:0] x_reg, x_next, y_reg, y_next;
    logic [WW-1:0] w_reg, w_next;
    logic          last_reg, last_next;
    logic [MW-1:0] m_reg, m_next;
    logic          neg_reg, neg_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic signed [AW-1:0] cross_reg, cross_next, xx_reg, xx_next, yy_reg, yy_next;
    logic          ovf_reg, ovf_next;
    logic [BIG_W-1:0] big_reg, big_next;
    logic [RW-1:0] d_reg, d_next, e_reg, e_next, f_reg, f_next, s_reg, s_next;
    logic [Q_W-1:0] q_reg, q_next;
    logic          out_valid_reg, out_valid_next;
    logic signed [COEF_W-1:0] coef_reg, coef_next;
    logic          degen_reg, degen_next, sat_reg, sat_next;

    logic [SW-1:0]        x_mag, y_mag;
    logic [2*MUL_W-1:0]   m_ext;
    logic [2*LIMB_W-1:0]  c_mag, xx_ext, yy_ext, sq_a, sq_b;
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   mul_p;
    logic [PW-1:0]        wp_sh;
    logic signed [SUM_W-1:0] p_ext, acc_ext, sum_ext, max_ext;
    logic signed [AW-1:0] acc_sel, acc_sat, acc_max;
    logic                 acc_ovf;
    logic [1:0]           limb_pos;
    logic [BIG_W-1:0]     pp_shifted;
    logic [RW:0]          diff;
    logic [Q_W-1:0]       q_clamp;
    logic                 degen_now;

    assign acc_max = {1'b0, {(AW-1){1'b1}}};

    // Magnitudes of the held samples and sums
    always_comb
    begin
        x_mag  = x_reg[SW-1] ? SW'(~x_reg + 1'b1) : x_reg;
        y_mag  = y_reg[SW-1] ? SW'(~y_reg + 1'b1) : y_reg;
        m_ext  = (2*MUL_W)'(m_reg);
        c_mag  = cross_reg[AW-1] ? (2*LIMB_W)'(AW'(~cross_reg + 1'b1))
                                 : (2*LIMB_W)'(cross_reg);
        xx_ext = (2*LIMB_W)'(xx_reg);
        yy_ext = (2*LIMB_W)'(yy_reg);
        sq_a   = cmd.sq_pair ? xx_ext : c_mag;
        sq_b   = cmd.sq_pair ? yy_ext : c_mag;
    end

    // Select the operands of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            DP_MAG:
            begin
                case (cmd.term)
                    TERM_CROSS: begin mul_a = MUL_W'(x_mag); mul_b = MUL_W'(y_mag); end
                    TERM_XX:    begin mul_a = MUL_W'(x_mag); mul_b = MUL_W'(x_mag); end
                    TERM_YY:    begin mul_a = MUL_W'(y_mag); mul_b = MUL_W'(y_mag); end
                    default:    begin mul_a = '0; mul_b = '0; end
                endcase
            end
            DP_WLO:
            begin
                mul_a = m_ext[MUL_W-1:0];
                mul_b = MUL_W'(w_reg);
            end
            DP_WHI:
            begin
                mul_a = m_ext[2*MUL_W-1:MUL_W];
                mul_b = MUL_W'(w_reg);
            end
            DP_SQ_MUL:
            begin
                mul_a = sq_a[cmd.limb_a*LIMB_W +: LIMB_W];
                mul_b = sq_b[cmd.limb_b*LIMB_W +: LIMB_W];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Saturating add of the signed weighted product into the chosen sum
    always_comb
    begin
        case (cmd.term)
            TERM_CROSS: acc_sel = cross_reg;
            TERM_XX:    acc_sel = xx_reg;
            TERM_YY:    acc_sel = yy_reg;
            default:    acc_sel = '0;
        endcase
        wp_sh   = wp_reg >> PROD_SHIFT;
        p_ext   = $signed(SUM_W'(wp_sh));
        if (neg_reg)
        begin
            p_ext = -p_ext;
        end
        acc_ext = SUM_W'(acc_sel);
        max_ext = SUM_W'(acc_max);
        sum_ext = acc_ext + p_ext;
        acc_ovf = 1'b0;
        if (sum_ext > max_ext)
        begin
            acc_sat = acc_max;
            acc_ovf = 1'b1;
        end
        else if (sum_ext < -max_ext)
        begin
            acc_sat = -acc_max;
            acc_ovf = 1'b1;
        end
        else
        begin
            acc_sat = sum_ext[AW-1:0];
        end
    end

    // Place a limb product at its weight in the wide product; also the root difference, clamp and degenerate test
    always_comb
    begin
        limb_pos   = {1'b0, cmd.limb_a} + {1'b0, cmd.limb_b};
        pp_shifted = BIG_W'(mul_p) << (LIMB_W * limb_pos);
        diff       = {1'b0, d_reg} - {1'b0, s_reg};
        q_clamp    = (q_reg > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : q_reg;
        degen_now  = xx_reg[AW-1] || (xx_reg == '0) || yy_reg[AW-1] || (yy_reg == '0);
    end

    // Next state of the datapath registers
    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        last_next      = last_reg;
        m_next         = m_reg;
        neg_next       = neg_reg;
        wp_next        = wp_reg;
        cross_next     = cross_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        ovf_next       = ovf_reg;
        big_next       = big_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        f_next         = f_reg;
        s_next         = s_reg;
        q_next         = q_reg;
        coef_next      = coef_reg;
        degen_next     = degen_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (cmd.op)
            DP_LOAD:
            begin
                x_next    = x_value;
                y_next    = y_value;
                w_next    = use_weights_reg ? weight : {1'b1, {(WW-1){1'b0}}};
                last_next = last;
            end
            DP_MAG:
            begin
                m_next   = MW'(mul_p);
                neg_next = (cmd.term == TERM_CROSS) && (x_reg[SW-1] ^ y_reg[SW-1]);
            end
            DP_WLO:
            begin
                wp_next = PW'(mul_p);
            end
            DP_WHI:
            begin
                wp_next = wp_reg + PW'({mul_p, {MUL_W{1'b0}}});
            end
            DP_ACC:
            begin
                ovf_next = ovf_reg || acc_ovf;
                case (cmd.term)
                    TERM_CROSS: cross_next = acc_sat;
                    TERM_XX:    xx_next    = acc_sat;
                    TERM_YY:    yy_next    = acc_sat;
                    default:    cross_next = cross_reg;
                endcase
            end
            DP_SQ_MUL:
            begin
                big_next = (cmd.first ? '0 : big_reg) + pp_shifted;
            end
            DP_LOAD_R:
            begin
                d_next = RW'({big_reg, {ROOT_SHIFT{1'b0}}});
            end
            DP_LOAD_B:
            begin
                f_next = RW'({big_reg, {ROOT_SHIFT{1'b0}}});
                e_next = '0;
                q_next = '0;
            end
            DP_ROOT_A:
            begin
                s_next = e_reg + f_reg;
            end
            DP_ROOT_B:
            begin
                f_next = f_reg >> 2;
                if (!diff[RW])
                begin
                    d_next = diff[RW-1:0];
                    e_next = (e_reg >> 1) + f_reg;
                    q_next = {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    e_next = e_reg >> 1;
                    q_next = {q_reg[Q_W-2:0], 1'b0};
                end
            end
            DP_EMIT:
            begin
                out_valid_next = 1'b1;
                degen_next     = degen_now;
                sat_next       = ovf_reg;
                if (degen_now)
                begin
                    coef_next = '0;
                end
                else if (cross_reg[AW-1])
                begin
                    coef_next = ~COEF_W'(q_clamp) + 1'b1;
                end
                else
                begin
                    coef_next = COEF_W'(q_clamp);
                end
                cross_next = '0;
                xx_next    = '0;
                yy_next    = '0;
                ovf_next   = 1'b0;
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    // Control registers and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_weights_reg <= 1'b0;
            cross_reg       <= '0;
            xx_reg          <= '0;
            yy_reg          <= '0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                use_weights_reg <= cfg_write_data;
            end
            cross_reg     <= cross_next;
            xx_reg        <= xx_next;
            yy_reg        <= yy_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        w_reg     <= w_next;
        last_reg  <= last_next;
        m_reg     <= m_next;
        neg_reg   <= neg_next;
        wp_reg    <= wp_next;
        big_reg   <= big_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        f_reg     <= f_next;
        s_reg     <= s_next;
        q_reg     <= q_next;
        coef_reg  <= coef_next;
        degen_reg <= degen_next;
        sat_reg   <= sat_next;
    end

    assign status.last     = last_reg;
    assign status.degen    = degen_now;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign coefficient = coef_reg;
    assign degenerate  = degen_reg;
    assign saturated   = sat_reg;

endmodule

`default_nettype wire

FILE: rtl/core/wca_controller.sv
// Controller: sequences the product, accumulate, squaring and root steps.
`timescale 1ns / 1ps
`default_nettype none

module wca_controller
    import wca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire wca_status_t status,
    output      wca_cmd_t    cmd
);

    ctrl_state_t      state_reg, state_next;
    term_t            term_reg, term_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MAG;
                    term_next  = TERM_CROSS;
                end
            end
            ST_MAG: state_next = ST_WLO;
            ST_WLO: state_next = ST_WHI;
            ST_WHI: state_next = ST_ACC;
            ST_ACC:
            begin
                case (term_reg)
                    TERM_CROSS: begin term_next = TERM_XX; state_next = ST_MAG; end
                    TERM_XX:    begin term_next = TERM_YY; state_next = ST_MAG; end
                    default:    state_next = ST_CHECK;
                endcase
            end
            ST_CHECK:
            begin
                cnt_next = '0;
                if (!status.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.degen)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SQC;
                end
            end
            ST_SQC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(3))
                begin
                    cnt_next   = '0;
                    state_next = ST_LDR;
                end
            end
            ST_LDR: state_next = ST_SQB;
            ST_SQB:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(3))
                begin
                    cnt_next   = '0;
                    state_next = ST_LDB;
                end
            end
            ST_LDB: state_next = ST_RTA;
            ST_RTA: state_next = ST_RTB;
            ST_RTB:
            begin
                cnt_next   = cnt_reg + 1'b1;
                state_next = (cnt_reg == CNT_W'(ROOT_STEPS - 1)) ? ST_EMIT : ST_RTA;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd.op      = DP_NOP;
        cmd.term    = term_reg;
        cmd.limb_a  = cnt_reg[1];
        cmd.limb_b  = cnt_reg[0];
        cmd.first   = (cnt_reg == '0);
        cmd.sq_pair = 1'b0;
        in_stall    = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE: cmd.op = in_valid ? DP_LOAD : DP_NOP;
            ST_MAG:  cmd.op = DP_MAG;
            ST_WLO:  cmd.op = DP_WLO;
            ST_WHI:  cmd.op = DP_WHI;
            ST_ACC:  cmd.op = DP_ACC;
            ST_SQC:  cmd.op = DP_SQ_MUL;
            ST_LDR:  cmd.op = DP_LOAD_R;
            ST_SQB:
            begin
                cmd.op      = DP_SQ_MUL;
                cmd.sq_pair = 1'b1;
            end
            ST_LDB:  cmd.op = DP_LOAD_B;
            ST_RTA:  cmd.op = DP_ROOT_A;
            ST_RTB:  cmd.op = DP_ROOT_B;
            ST_EMIT: cmd.op = status.out_free ? DP_EMIT : DP_NOP;
            default: cmd.op = DP_NOP;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= TERM_CROSS;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/weighted_correlation_accumulator.sv
// Top level: weighted correlation accumulator (controller plus datapath).
// Each pair runs 3 terms x 4 steps on one shared 32x32 multiplier; no new pair is taken until it is through.
// A pair marked last then runs 8 limb products and a 15-step root search, skipped when degenerate.
// The result transfer after the last pair can be held by output stalls.
// Reset clears the sums, the saturation flag, use_weights and the output valid at once.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module weighted_correlation_accumulator
    import wca_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int WEIGHT_WIDTH = 16,
    parameter int ACC_WIDTH    = 64
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_enable,
    input  wire logic                           cfg_write_data,
    input  wire logic                           in_valid,
    output      logic                           in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] x_value,
    input  wire logic signed [SAMPLE_WIDTH-1:0] y_value,
    input  wire logic        [WEIGHT_WIDTH-1:0] weight,
    input  wire logic                           last,
    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      logic signed [COEF_W-1:0]       coefficient,
    output      logic                           degenerate,
    output      logic                           saturated
);

    wca_cmd_t    cmd;
    wca_status_t status;

    wca_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    wca_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .WEIGHT_WIDTH (WEIGHT_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .x_value          (x_value),
        .y_value          (y_value),
        .weight           (weight),
        .last             (last),
        .cmd              (cmd),
        .status           (status),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .coefficient      (coefficient),
        .degenerate       (degenerate),
        .saturated        (saturated)
    );

    // An input transfer always captures the item
    `WCA_ASSERT_IMPLIES(a_accept_loads, clk, rst_n, in_valid && !in_stall, cmd.op == DP_LOAD)
    // A result is written only into a free output slot
    `WCA_ASSERT_IMPLIES(a_emit_slot_free, clk, rst_n, cmd.op == DP_EMIT, !out_valid || !out_stall)
    // A written result is offered next cycle
    `WCA_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.op == DP_EMIT, out_valid)
    // A degenerate series reports a zero coefficient
    `WCA_ASSERT_IMPLIES(a_degen_zero, clk, rst_n, out_valid && degenerate, coefficient == '0)

endmodule

`default_nettype wire
